### hw/rtl/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types, codes and helpers of the line follower motor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcf_pkg;

  localparam logic [3:0] CMD_SAMPLE  = 4'd0;
  localparam logic [3:0] CMD_CARD    = 4'd1;
  localparam logic [3:0] CMD_TICK    = 4'd2;
  localparam logic [3:0] CMD_STOP    = 4'd3;
  localparam logic [3:0] CMD_START   = 4'd4;
  localparam logic [3:0] CMD_LEFT    = 4'd5;
  localparam logic [3:0] CMD_RIGHT   = 4'd6;
  localparam logic [3:0] CMD_ALLUP   = 4'd7;
  localparam logic [3:0] CMD_ALLDOWN = 4'd8;
  localparam logic [3:0] CMD_COAST   = 4'd9;
  localparam logic [3:0] CMD_BRAKE   = 4'd10;
  localparam logic [3:0] CMD_UP      = 4'd11;
  localparam logic [3:0] CMD_DOWN    = 4'd12;
  localparam logic [3:0] CMD_SPEED   = 4'd13;

  localparam logic [2:0] MODE_STOP  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;

  localparam logic [1:0] PINS_BRAKE   = 2'd0;
  localparam logic [1:0] PINS_REVERSE = 2'd1;
  localparam logic [1:0] PINS_FORWARD = 2'd2;
  localparam logic [1:0] PINS_COAST   = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_CARD      = 1'b1;

  localparam logic [9:0] THRESHOLD_RESET = 10'd20;
  localparam logic [7:0] CARD_RESET      = 8'd0;
  localparam logic [7:0] POLL_ADDR       = 8'hC1;

  localparam logic signed [9:0] PULSE_LIMIT = 10'sd99;
  localparam logic signed [9:0] PULSE_STEP  = 10'sd1;
  localparam logic signed [9:0] TURN_OFFSET = 10'sd5;

  typedef struct packed {
    logic [3:0]         cmd;
    logic               motor_sel;
    logic [7:0]         value;
    logic signed [10:0] err;
  } entry_t;

  function automatic logic [7:0] abs_mag(input logic signed [7:0] v);
    abs_mag = v[7] ? 8'(-v) : 8'(v);
  endfunction

  function automatic logic signed [7:0] sat_pulse(input logic signed [9:0] p);
    logic signed [9:0] q;
    q = p;
    if (p > PULSE_LIMIT) begin
      q = PULSE_LIMIT;
    end else if (p < -PULSE_LIMIT) begin
      q = -PULSE_LIMIT;
    end
    sat_pulse = q[7:0];
  endfunction

  function automatic logic [1:0] pins_for(input logic signed [7:0] p);
    pins_for = (p > 8'sd0) ? PINS_FORWARD : PINS_REVERSE;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcf_front.sv
// ----------------------------------------------------------------------------
// lcf_front
// Accepts items and works out the probe balance before queueing them.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_front (
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [3:0]         cmd,
  input  wire logic               motor_sel,
  input  wire logic [7:0]         value,
  input  wire logic signed [7:0]  mag_0,
  input  wire logic signed [7:0]  mag_1,
  input  wire logic signed [7:0]  mag_2,
  input  wire logic signed [7:0]  mag_3,
  input  wire logic signed [7:0]  mag_4,
  input  wire logic signed [7:0]  mag_5,
  input  wire logic signed [7:0]  mag_6,
  input  wire logic signed [7:0]  mag_7,
  input  wire logic               q_full,
  output logic                    q_push,
  output lcf_pkg::entry_t         q_entry
);

  logic [9:0] left_sum;
  logic [9:0] right_sum;

  always_comb begin
    left_sum  = 10'(lcf_pkg::abs_mag(mag_0)) + 10'(lcf_pkg::abs_mag(mag_1))
              + 10'(lcf_pkg::abs_mag(mag_2)) + 10'(lcf_pkg::abs_mag(mag_3));
    right_sum = 10'(lcf_pkg::abs_mag(mag_7)) + 10'(lcf_pkg::abs_mag(mag_6))
              + 10'(lcf_pkg::abs_mag(mag_5)) + 10'(lcf_pkg::abs_mag(mag_4));
  end

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_entry.cmd       = cmd;
    q_entry.motor_sel = motor_sel;
    q_entry.value     = value;
    q_entry.err       = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
  end

endmodule

`default_nettype wire

### hw/rtl/lcf_queue.sv
// ----------------------------------------------------------------------------
// lcf_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lcf_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output lcf_pkg::entry_t       head,
  output logic                  head_valid
);

  lcf_pkg::entry_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcf_back.sv
// ----------------------------------------------------------------------------
// lcf_back
// Carries out queued items on the drive state; the state is the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lcf_pkg::entry_t   head,
  input  wire logic              head_valid,
  output logic                   pop,
  input  wire logic [9:0]        guide_threshold,
  input  wire logic [7:0]        target_card,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [2:0]             moving_mode,
  output logic signed [7:0]      pulse_left,
  output logic signed [7:0]      pulse_right,
  output logic [1:0]             pins_left,
  output logic [1:0]             pins_right,
  output logic                   poll_request,
  output logic                   led_level,
  output logic signed [10:0]     line_error
);

  logic [2:0]         mode;
  logic signed [7:0]  pulse [2];
  logic [1:0]         pins [2];
  logic [7:0]         cruise;
  logic               lamp;
  logic signed [10:0] last_error;
  logic               poll;

  logic [2:0]         mode_next;
  logic signed [7:0]  pulse_next [2];
  logic [1:0]         pins_next [2];
  logic [7:0]         cruise_next;
  logic               lamp_next;
  logic signed [10:0] last_error_next;
  logic               poll_next;

  logic signed [9:0]  cruise_s;
  logic signed [9:0]  p0_s;
  logic signed [9:0]  p1_s;
  logic signed [9:0]  pm_s;
  logic signed [11:0] err_s;
  logic signed [11:0] thr_s;
  logic [11:0]        err_abs;

  assign pop = head_valid && (!result_valid || !result_stall);

  always_comb begin
    cruise_s = $signed({2'b00, cruise});
    p0_s     = 10'(pulse[0]);
    p1_s     = 10'(pulse[1]);
    pm_s     = 10'(pulse[head.motor_sel]);
    err_s    = 12'(head.err);
    thr_s    = $signed({2'b00, guide_threshold});
    err_abs  = err_s[11] ? 12'(-err_s) : 12'(err_s);
  end

  always_comb begin
    mode_next       = mode;
    pulse_next[0]   = pulse[0];
    pulse_next[1]   = pulse[1];
    pins_next[0]    = pins[0];
    pins_next[1]    = pins[1];
    cruise_next     = cruise;
    lamp_next       = lamp;
    last_error_next = last_error;
    poll_next       = 1'b0;
    case (head.cmd)
      lcf_pkg::CMD_SAMPLE: begin
        if (mode != lcf_pkg::MODE_STOP) begin
          last_error_next = head.err;
          if ($signed(err_abs) < thr_s) begin
            mode_next     = lcf_pkg::MODE_FWD;
            pulse_next[0] = lcf_pkg::sat_pulse(cruise_s);
            pulse_next[1] = lcf_pkg::sat_pulse(cruise_s);
          end else if (err_s < -thr_s && mode != lcf_pkg::MODE_LEFT) begin
            mode_next     = lcf_pkg::MODE_LEFT;
            pulse_next[0] = lcf_pkg::sat_pulse(cruise_s - lcf_pkg::TURN_OFFSET);
            pulse_next[1] = lcf_pkg::sat_pulse(cruise_s + lcf_pkg::TURN_OFFSET);
          end else if (err_s > thr_s && mode != lcf_pkg::MODE_RIGHT) begin
            mode_next     = lcf_pkg::MODE_RIGHT;
            pulse_next[0] = lcf_pkg::sat_pulse(cruise_s + lcf_pkg::TURN_OFFSET);
            pulse_next[1] = lcf_pkg::sat_pulse(cruise_s - lcf_pkg::TURN_OFFSET);
          end
          if (mode_next != mode || $signed(err_abs) < thr_s) begin
            pins_next[0] = lcf_pkg::pins_for(pulse_next[0]);
            pins_next[1] = lcf_pkg::pins_for(pulse_next[1]);
          end
        end
      end
      lcf_pkg::CMD_CARD: begin
        if (head.value == target_card) begin
          mode_next    = lcf_pkg::MODE_STOP;
          pins_next[0] = lcf_pkg::PINS_BRAKE;
          pins_next[1] = lcf_pkg::PINS_BRAKE;
        end
      end
      lcf_pkg::CMD_TICK: begin
        if (mode != lcf_pkg::MODE_STOP) begin
          poll_next = 1'b1;
          lamp_next = ~lamp;
        end
      end
      lcf_pkg::CMD_STOP: begin
        mode_next    = lcf_pkg::MODE_STOP;
        pins_next[0] = lcf_pkg::PINS_BRAKE;
        pins_next[1] = lcf_pkg::PINS_BRAKE;
      end
      lcf_pkg::CMD_START: begin
        mode_next    = lcf_pkg::MODE_FWD;
        pins_next[0] = lcf_pkg::PINS_FORWARD;
        pins_next[1] = lcf_pkg::PINS_FORWARD;
      end
      lcf_pkg::CMD_LEFT: begin
        mode_next     = lcf_pkg::MODE_LEFT;
        pulse_next[0] = lcf_pkg::sat_pulse(p0_s - lcf_pkg::TURN_OFFSET);
        pulse_next[1] = lcf_pkg::sat_pulse(p1_s + lcf_pkg::TURN_OFFSET);
        pins_next[0]  = lcf_pkg::pins_for(pulse_next[0]);
        pins_next[1]  = lcf_pkg::pins_for(pulse_next[1]);
      end
      lcf_pkg::CMD_RIGHT: begin
        mode_next     = lcf_pkg::MODE_RIGHT;
        pulse_next[0] = lcf_pkg::sat_pulse(p0_s + lcf_pkg::TURN_OFFSET);
        pulse_next[1] = lcf_pkg::sat_pulse(p1_s - lcf_pkg::TURN_OFFSET);
        pins_next[0]  = lcf_pkg::pins_for(pulse_next[0]);
        pins_next[1]  = lcf_pkg::pins_for(pulse_next[1]);
      end
      lcf_pkg::CMD_ALLUP: begin
        pulse_next[0] = lcf_pkg::sat_pulse(p0_s + lcf_pkg::PULSE_STEP);
        pulse_next[1] = lcf_pkg::sat_pulse(p1_s + lcf_pkg::PULSE_STEP);
        pins_next[0]  = lcf_pkg::pins_for(pulse_next[0]);
        pins_next[1]  = lcf_pkg::pins_for(pulse_next[1]);
      end
      lcf_pkg::CMD_ALLDOWN: begin
        pulse_next[0] = lcf_pkg::sat_pulse(p0_s - lcf_pkg::PULSE_STEP);
        pulse_next[1] = lcf_pkg::sat_pulse(p1_s - lcf_pkg::PULSE_STEP);
        pins_next[0]  = lcf_pkg::pins_for(pulse_next[0]);
        pins_next[1]  = lcf_pkg::pins_for(pulse_next[1]);
      end
      lcf_pkg::CMD_COAST: begin
        pins_next[head.motor_sel] = lcf_pkg::PINS_COAST;
      end
      lcf_pkg::CMD_BRAKE: begin
        pins_next[head.motor_sel] = lcf_pkg::PINS_BRAKE;
      end
      lcf_pkg::CMD_UP: begin
        pulse_next[head.motor_sel] = lcf_pkg::sat_pulse(pm_s + lcf_pkg::PULSE_STEP);
        pins_next[head.motor_sel]  = lcf_pkg::pins_for(pulse_next[head.motor_sel]);
      end
      lcf_pkg::CMD_DOWN: begin
        pulse_next[head.motor_sel] = lcf_pkg::sat_pulse(pm_s - lcf_pkg::PULSE_STEP);
        pins_next[head.motor_sel]  = lcf_pkg::pins_for(pulse_next[head.motor_sel]);
      end
      lcf_pkg::CMD_SPEED: begin
        cruise_next = head.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lcf_pkg::MODE_STOP;
      pulse[0]     <= 8'sd0;
      pulse[1]     <= 8'sd0;
      pins[0]      <= lcf_pkg::PINS_BRAKE;
      pins[1]      <= lcf_pkg::PINS_BRAKE;
      cruise       <= 8'd0;
      lamp         <= 1'b0;
      last_error   <= 11'sd0;
      poll         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode       <= mode_next;
        pulse[0]   <= pulse_next[0];
        pulse[1]   <= pulse_next[1];
        pins[0]    <= pins_next[0];
        pins[1]    <= pins_next[1];
        cruise     <= cruise_next;
        lamp       <= lamp_next;
        last_error <= last_error_next;
        poll       <= poll_next;
      end
      if (pop) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign moving_mode  = mode;
  assign pulse_left   = pulse[0];
  assign pulse_right  = pulse[1];
  assign pins_left    = pins[0];
  assign pins_right   = pins[1];
  assign poll_request = poll;
  assign led_level    = lamp;
  assign line_error   = last_error;

endmodule

`default_nettype wire

### hw/rtl/line_follow_motor_controller.sv
// ----------------------------------------------------------------------------
// line_follow_motor_controller
// Two-motor drive controller for a magnetic line follower.
//
//   channel   direction  handshake             payload
//   item      in         item_valid/item_stall cmd, motor_sel, value, mag_0..7
//   result    out        result_valid/stall    mode, pulses, pins, poll, led, err
//   cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained unless a result stall fills the queue; a result
// is registered at the edge that takes the item off the two-entry queue.
// The probe balance is summed in the front part, the drive update in the back.
// Reset is synchronous and leaves the vehicle stopped with both motors braked.
// A stalled result holds; the queue absorbs two items before item_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_motor_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [3:0]         cmd,
  input  wire logic               motor_sel,
  input  wire logic [7:0]         value,
  input  wire logic signed [7:0]  mag_0,
  input  wire logic signed [7:0]  mag_1,
  input  wire logic signed [7:0]  mag_2,
  input  wire logic signed [7:0]  mag_3,
  input  wire logic signed [7:0]  mag_4,
  input  wire logic signed [7:0]  mag_5,
  input  wire logic signed [7:0]  mag_6,
  input  wire logic signed [7:0]  mag_7,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [2:0]              moving_mode,
  output logic signed [7:0]       pulse_left,
  output logic signed [7:0]       pulse_right,
  output logic [1:0]              pins_left,
  output logic [1:0]              pins_right,
  output logic                    poll_request,
  output logic                    led_level,
  output logic signed [10:0]      line_error,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [9:0]         cfg_data
);

  logic             q_full;
  logic             q_push;
  lcf_pkg::entry_t  q_entry;
  logic             q_pop;
  lcf_pkg::entry_t  q_head;
  logic             q_head_valid;
  logic [9:0]       guide_threshold;
  logic [7:0]       target_card;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      guide_threshold <= lcf_pkg::THRESHOLD_RESET;
      target_card     <= lcf_pkg::CARD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcf_pkg::CFG_THRESHOLD: guide_threshold <= cfg_data;
        lcf_pkg::CFG_CARD:      target_card     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lcf_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .motor_sel  (motor_sel),
    .value      (value),
    .mag_0      (mag_0),
    .mag_1      (mag_1),
    .mag_2      (mag_2),
    .mag_3      (mag_3),
    .mag_4      (mag_4),
    .mag_5      (mag_5),
    .mag_6      (mag_6),
    .mag_7      (mag_7),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  lcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  lcf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .head_valid      (q_head_valid),
    .pop             (q_pop),
    .guide_threshold (guide_threshold),
    .target_card     (target_card),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .moving_mode     (moving_mode),
    .pulse_left      (pulse_left),
    .pulse_right     (pulse_right),
    .pins_left       (pins_left),
    .pins_right      (pins_right),
    .poll_request    (poll_request),
    .led_level       (led_level),
    .line_error      (line_error)
  );

endmodule

`default_nettype wire

### hw/rtl/lcf_checker.sv
// ----------------------------------------------------------------------------
// lcf_checker
// Port-level checks of the line follower motor controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic [2:0]         moving_mode,
  input wire logic signed [7:0]  pulse_left,
  input wire logic signed [7:0]  pulse_right,
  input wire logic               poll_request,
  input wire logic signed [10:0] line_error
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(moving_mode)
      && $stable(pulse_left) && $stable(pulse_right) && $stable(line_error))
    else $error("stalled result changed");

  a_poll_moving: assert property (@(posedge clk) disable iff (rst)
    result_valid && poll_request |-> moving_mode != lcf_pkg::MODE_STOP)
    else $error("poll request while stopped");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pulse_left <= 8'sd99 && pulse_left >= -8'sd99
      && pulse_right <= 8'sd99 && pulse_right >= -8'sd99)
    else $error("pulse out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result right after reset");

endmodule

bind line_follow_motor_controller lcf_checker u_lcf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .moving_mode  (moving_mode),
  .pulse_left   (pulse_left),
  .pulse_right  (pulse_right),
  .poll_request (poll_request),
  .line_error   (line_error)
);

`default_nettype wire

### dv/line_follow_motor_controller_tb.sv
// ----------------------------------------------------------------------------
// line_follow_motor_controller_tb
// Self-checking bench for the line follower drive controller. Items and
// results use valid/stall handshakes, and the register port uses valid/ready.
// A scoreboard class tracks the drive state and predicts one status result
// for each accepted item. Results are compared field by field. The run starts
// with a directed sequence, then random phases at several register settings.
// The sender works in bursts, and the receiver stalls at varying duty.
// ----------------------------------------------------------------------------

module line_follow_motor_controller_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] CMD_SPARE_0 = 4'd14;
  localparam logic [3:0] CMD_SPARE_1 = 4'd15;

  localparam int DRIVE_LIMIT = int'(lcf_pkg::PULSE_LIMIT);
  localparam int DRIVE_STEP  = int'(lcf_pkg::PULSE_STEP);
  localparam int TURN_STEP   = int'(lcf_pkg::TURN_OFFSET);
  localparam int ERR_SPAN    = 512;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 155;
  localparam int MAX_PRINT   = 30;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]         mode;
    logic signed [7:0]  pulse_l;
    logic signed [7:0]  pulse_r;
    logic [1:0]         pins_l;
    logic [1:0]         pins_r;
    logic               poll;
    logic               led;
    logic signed [10:0] err;
  } drive_status_t;

  class drive_scoreboard;
    logic [9:0]    threshold;
    logic [7:0]    stop_card;
    logic [2:0]    mode;
    int            pulse [2];
    logic [1:0]    pins [2];
    int            cruise;
    logic          lamp;
    int            last_err;
    drive_status_t status_q [$];
    int            n_items;
    int            n_results;
    int            n_errors;
    int            n_turns;
    int            n_guided;

    function new();
      threshold = lcf_pkg::THRESHOLD_RESET;
      stop_card = lcf_pkg::CARD_RESET;
      mode      = lcf_pkg::MODE_STOP;
      pulse[0]  = 0;
      pulse[1]  = 0;
      pins[0]   = lcf_pkg::PINS_BRAKE;
      pins[1]   = lcf_pkg::PINS_BRAKE;
      cruise    = 0;
      lamp      = 1'b0;
      last_err  = 0;
      n_items   = 0;
      n_results = 0;
      n_errors  = 0;
      n_turns   = 0;
      n_guided  = 0;
    endfunction

    function void set_reg(logic idx, logic [9:0] data);
      if (idx == lcf_pkg::CFG_THRESHOLD) begin
        threshold = data;
      end else begin
        stop_card = data[7:0];
      end
    endfunction

    function void set_drive(int m, int p);
      if (p > DRIVE_LIMIT) p = DRIVE_LIMIT;
      if (p < -DRIVE_LIMIT) p = -DRIVE_LIMIT;
      pulse[m] = p;
      pins[m] = (p > 0) ? lcf_pkg::PINS_FORWARD : lcf_pkg::PINS_REVERSE;
    endfunction

    function void halt();
      mode = lcf_pkg::MODE_STOP;
      pins[0] = lcf_pkg::PINS_BRAKE;
      pins[1] = lcf_pkg::PINS_BRAKE;
    endfunction

    function void follow_line(logic signed [7:0] m [8]);
      int sum;
      int a;
      int b;
      int thr;
      if (mode == lcf_pkg::MODE_STOP) return;
      n_guided++;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        a = int'(m[i]);
        b = int'(m[7 - i]);
        sum += ((a < 0) ? -a : a) - ((b < 0) ? -b : b);
      end
      last_err = sum;
      thr = int'(threshold);
      if (((sum < 0) ? -sum : sum) < thr) begin
        mode = lcf_pkg::MODE_FWD;
        set_drive(0, cruise);
        set_drive(1, cruise);
      end
      if (sum < -thr && mode != lcf_pkg::MODE_LEFT) begin
        mode = lcf_pkg::MODE_LEFT;
        set_drive(0, cruise - TURN_STEP);
        set_drive(1, cruise + TURN_STEP);
        n_turns++;
      end
      if (sum > thr && mode != lcf_pkg::MODE_RIGHT) begin
        mode = lcf_pkg::MODE_RIGHT;
        set_drive(0, cruise + TURN_STEP);
        set_drive(1, cruise - TURN_STEP);
        n_turns++;
      end
    endfunction

    function void note_item(logic [3:0] c, logic s, logic [7:0] v, logic signed [7:0] m [8]);
      drive_status_t st;
      logic poll;
      int sel;
      poll = 1'b0;
      sel = int'(s);
      n_items++;
      case (c)
        lcf_pkg::CMD_SAMPLE: follow_line(m);
        lcf_pkg::CMD_CARD: begin
          if (v == stop_card) halt();
        end
        lcf_pkg::CMD_TICK: begin
          if (mode != lcf_pkg::MODE_STOP) begin
            poll = 1'b1;
            lamp = ~lamp;
          end
        end
        lcf_pkg::CMD_STOP: halt();
        lcf_pkg::CMD_START: begin
          mode = lcf_pkg::MODE_FWD;
          pins[0] = lcf_pkg::PINS_FORWARD;
          pins[1] = lcf_pkg::PINS_FORWARD;
        end
        lcf_pkg::CMD_LEFT: begin
          mode = lcf_pkg::MODE_LEFT;
          set_drive(0, pulse[0] - TURN_STEP);
          set_drive(1, pulse[1] + TURN_STEP);
        end
        lcf_pkg::CMD_RIGHT: begin
          mode = lcf_pkg::MODE_RIGHT;
          set_drive(0, pulse[0] + TURN_STEP);
          set_drive(1, pulse[1] - TURN_STEP);
        end
        lcf_pkg::CMD_ALLUP: begin
          set_drive(0, pulse[0] + DRIVE_STEP);
          set_drive(1, pulse[1] + DRIVE_STEP);
        end
        lcf_pkg::CMD_ALLDOWN: begin
          set_drive(0, pulse[0] - DRIVE_STEP);
          set_drive(1, pulse[1] - DRIVE_STEP);
        end
        lcf_pkg::CMD_COAST: pins[sel] = lcf_pkg::PINS_COAST;
        lcf_pkg::CMD_BRAKE: pins[sel] = lcf_pkg::PINS_BRAKE;
        lcf_pkg::CMD_UP: set_drive(sel, pulse[sel] + DRIVE_STEP);
        lcf_pkg::CMD_DOWN: set_drive(sel, pulse[sel] - DRIVE_STEP);
        lcf_pkg::CMD_SPEED: cruise = int'(v);
        default: ;
      endcase
      st.mode    = mode;
      st.pulse_l = 8'(pulse[0]);
      st.pulse_r = 8'(pulse[1]);
      st.pins_l  = pins[0];
      st.pins_r  = pins[1];
      st.poll    = poll;
      st.led     = lamp;
      st.err     = 11'(last_err);
      status_q.push_back(st);
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= MAX_PRINT) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic signed [10:0] got, logic signed [10:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                  n_results, name, got, want));
      end
    endtask

    task check_result(drive_status_t got);
      drive_status_t want;
      if (status_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      want = status_q.pop_front();
      compare_field("moving_mode", {8'd0, got.mode}, {8'd0, want.mode});
      compare_field("pulse_left", 11'(got.pulse_l), 11'(want.pulse_l));
      compare_field("pulse_right", 11'(got.pulse_r), 11'(want.pulse_r));
      compare_field("pins_left", {9'd0, got.pins_l}, {9'd0, want.pins_l});
      compare_field("pins_right", {9'd0, got.pins_r}, {9'd0, want.pins_r});
      compare_field("poll_request", {10'd0, got.poll}, {10'd0, want.poll});
      compare_field("led_level", {10'd0, got.led}, {10'd0, want.led});
      compare_field("line_error", got.err, want.err);
      n_results++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [3:0]        cmd = lcf_pkg::CMD_SAMPLE;
  logic              motor_sel = 1'b0;
  logic [7:0]        value = 8'd0;
  logic signed [7:0] drv_mag [8] = '{default: 8'sd0};
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [2:0]        moving_mode;
  logic signed [7:0] pulse_left;
  logic signed [7:0] pulse_right;
  logic [1:0]        pins_left;
  logic [1:0]        pins_right;
  logic              poll_request;
  logic              led_level;
  logic signed [10:0] line_error;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = lcf_pkg::CFG_THRESHOLD;
  logic [9:0]        cfg_data = 10'd0;

  drive_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 1;
  int stall_pct = 0;
  int stall_timer = 0;
  int n_settings = 0;

  line_follow_motor_controller u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .motor_sel    (motor_sel),
    .value        (value),
    .mag_0        (drv_mag[0]),
    .mag_1        (drv_mag[1]),
    .mag_2        (drv_mag[2]),
    .mag_3        (drv_mag[3]),
    .mag_4        (drv_mag[4]),
    .mag_5        (drv_mag[5]),
    .mag_6        (drv_mag[6]),
    .mag_7        (drv_mag[7]),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .moving_mode  (moving_mode),
    .pulse_left   (pulse_left),
    .pulse_right  (pulse_right),
    .pins_left    (pins_left),
    .pins_right   (pins_right),
    .poll_request (poll_request),
    .led_level    (led_level),
    .line_error   (line_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_follow_motor_controller_tb: FAIL");
      $finish;
    end
  end

  // receiver stall duty is redrawn whenever its timer runs out, zero included
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 25;
          3: stall_pct <= 50;
          default: stall_pct <= 80;
        endcase
        stall_timer <= int'($urandom_range(20, 120));
      end else begin
        stall_timer <= stall_timer - 1;
      end
      result_stall <= (int'($urandom_range(0, 99)) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) sb.note_item(cmd, motor_sel, value, drv_mag);
  end

  always @(posedge clk) begin
    drive_status_t got;
    if (!rst && result_valid && !result_stall) begin
      got.mode    = moving_mode;
      got.pulse_l = pulse_left;
      got.pulse_r = pulse_right;
      got.pins_l  = pins_left;
      got.pins_r  = pins_right;
      got.poll    = poll_request;
      got.led     = led_level;
      got.err     = line_error;
      sb.check_result(got);
    end
  end

  function automatic logic signed [7:0] probe_of(int mag);
    logic signed [7:0] r;
    r = $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
    return r;
  endfunction

  // probe set whose balance equals e, with a random common level on each pair
  function automatic void shape_probes(int e, output logic signed [7:0] m [8]);
    int rem;
    int take;
    int base;
    int hi;
    rem = (e < 0) ? -e : e;
    for (int i = 0; i < 4; i++) begin
      take = (rem > 128) ? 128 : rem;
      rem -= take;
      base = int'($urandom_range(0, 128 - take));
      hi = (e >= 0) ? i : 7 - i;
      m[hi] = probe_of(take + base);
      m[7 - hi] = probe_of(base);
    end
  endfunction

  task automatic push_item(logic [3:0] c, logic s, logic [7:0] v, logic signed [7:0] m [8]);
    int gap;
    item_valid <= 1'b1;
    cmd <= c;
    motor_sel <= s;
    value <= v;
    for (int i = 0; i < 8; i++) drv_mag[i] <= m[i];
    do @(posedge clk); while (item_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = int'($urandom_range(1, 24));
      gap = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_cmd(logic [3:0] c, logic s, logic [7:0] v, int e);
    logic signed [7:0] m [8];
    shape_probes(e, m);
    push_item(c, s, v, m);
  endtask

  task automatic send_random();
    logic signed [7:0] m [8];
    logic [3:0] c;
    logic [7:0] v;
    int r;
    int thr;
    int e;
    thr = int'(sb.threshold);
    v = 8'($urandom);
    for (int i = 0; i < 8; i++) m[i] = 8'($urandom);
    r = int'($urandom_range(0, 99));
    if (r < 40) begin
      c = lcf_pkg::CMD_SAMPLE;
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: e = thr;
          1: e = -thr;
          2: e = thr + 1;
          3: e = -thr - 1;
          4: e = thr - 1;
          5: e = 1 - thr;
          6: e = 0;
          default: e = int'($urandom_range(0, 2 * ERR_SPAN)) - ERR_SPAN;
        endcase
        if (e > ERR_SPAN) e = ERR_SPAN;
        if (e < -ERR_SPAN) e = -ERR_SPAN;
        shape_probes(e, m);
      end
    end else if (r < 48) begin
      c = lcf_pkg::CMD_TICK;
    end else if (r < 53) begin
      c = lcf_pkg::CMD_CARD;
      if ($urandom_range(0, 9) < 6) v = sb.stop_card;
    end else if (r < 60) begin
      c = lcf_pkg::CMD_START;
    end else if (r < 63) begin
      c = lcf_pkg::CMD_STOP;
    end else if (r < 67) begin
      c = lcf_pkg::CMD_LEFT;
    end else if (r < 71) begin
      c = lcf_pkg::CMD_RIGHT;
    end else if (r < 74) begin
      c = lcf_pkg::CMD_ALLUP;
    end else if (r < 77) begin
      c = lcf_pkg::CMD_ALLDOWN;
    end else if (r < 80) begin
      c = lcf_pkg::CMD_COAST;
    end else if (r < 83) begin
      c = lcf_pkg::CMD_BRAKE;
    end else if (r < 87) begin
      c = lcf_pkg::CMD_UP;
    end else if (r < 91) begin
      c = lcf_pkg::CMD_DOWN;
    end else if (r < 98) begin
      c = lcf_pkg::CMD_SPEED;
      if ($urandom_range(0, 1)) v = 8'($urandom_range(0, 110));
    end else begin
      c = $urandom_range(0, 1) ? CMD_SPARE_0 : CMD_SPARE_1;
    end
    push_item(c, 1'($urandom_range(0, 1)), v, m);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic idx, logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  initial begin
    logic [9:0] thr_set [PHASES];
    logic [7:0] card_set [PHASES];
    thr_set  = '{10'd0, 10'd512, 10'd1, 10'($urandom_range(0, 512)), 10'd20,
                 10'($urandom_range(2, 100))};
    card_set = '{8'd255, 8'd0, 8'($urandom), 8'($urandom), 8'd255, 8'($urandom)};
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, threshold 20 and card 0
    send_cmd(lcf_pkg::CMD_TICK, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, 300);
    send_cmd(lcf_pkg::CMD_CARD, 1'b0, 8'h5a, 0);
    send_cmd(lcf_pkg::CMD_UP, 1'b1, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_DOWN, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_LEFT, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_RIGHT, 1'b1, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_COAST, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_COAST, 1'b1, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_BRAKE, 1'b1, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_SPEED, 1'b0, 8'd255, 0);
    send_cmd(lcf_pkg::CMD_START, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_TICK, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, 20);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, -ERR_SPAN);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, -ERR_SPAN);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, ERR_SPAN);
    send_cmd(lcf_pkg::CMD_ALLUP, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_SPEED, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_SAMPLE, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_ALLDOWN, 1'b0, 8'd0, 0);
    send_cmd(CMD_SPARE_0, 1'b1, 8'hff, 0);
    send_cmd(CMD_SPARE_1, 1'b0, 8'd0, 0);
    send_cmd(lcf_pkg::CMD_CARD, 1'b0, 8'd0, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(lcf_pkg::CFG_THRESHOLD, thr_set[p]);
      write_reg(lcf_pkg::CFG_CARD, {2'b00, card_set[p]});
      cfg_valid <= 1'b0;
      n_settings++;
      for (int k = 0; k < PHASE_ITEMS; k++) send_random();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register settings",
             sb.n_items, sb.n_results, n_settings);
    $display("line samples while moving %0d, guided turns %0d, mismatches %0d",
             sb.n_guided, sb.n_turns, sb.n_errors);
    if (sb.n_errors == 0 && sb.status_q.size() == 0) begin
      $display("line_follow_motor_controller_tb: PASS");
    end else begin
      $display("line_follow_motor_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
